>>> design/ccc_pkg.sv
// Shared constants, types and the divider step function of the color classifier.
package ccc_pkg;

	localparam int FREQ_W    = 18;
	localparam int FRAC_W    = 16;
	localparam int LVL_W     = FRAC_W + 1;
	localparam int SUM_W     = LVL_W + 1;
	localparam int HUE_W     = 12;
	localparam int CLASS_W   = 3;
	localparam int NUM_REGS  = 6;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	// Divider: quotient known to fit DIV_Q_W bits, so only DIV_Q_W steps are needed.
	localparam int DIV_N_W   = 34;
	localparam int DIV_D_W   = 18;
	localparam int DIV_Q_W   = 17;
	localparam int DIV_HI_W  = DIV_N_W - DIV_Q_W;

	localparam int NUM_W     = 31;
	localparam int LATENCY   = 2 * DIV_Q_W + 3;

	localparam logic [LVL_W-1:0] ONE_Q     = LVL_W'(1) << FRAC_W;
	localparam logic [HUE_W-1:0] HUE_MAX   = HUE_W'(3599);
	localparam logic [HUE_W-1:0] HUE_RED_HI  = HUE_W'(3300);
	localparam logic [HUE_W-1:0] HUE_RED_LO  = HUE_W'(200);
	localparam logic [HUE_W-1:0] HUE_GRN_LO  = HUE_W'(800);
	localparam logic [HUE_W-1:0] HUE_GRN_HI  = HUE_W'(1600);
	localparam logic [HUE_W-1:0] HUE_BLU_LO  = HUE_W'(1900);
	localparam logic [HUE_W-1:0] HUE_BLU_HI  = HUE_W'(2700);

	typedef enum logic [CLASS_W-1:0] {
		CLS_BLACK   = 3'd0,
		CLS_WHITE   = 3'd1,
		CLS_RED     = 3'd2,
		CLS_GREEN   = 3'd3,
		CLS_BLUE    = 3'd4,
		CLS_UNKNOWN = 3'd5
	} color_class_t;

	typedef enum logic [2:0] {
		REG_RED_BLACK   = 3'd0,
		REG_RED_WHITE   = 3'd1,
		REG_GREEN_BLACK = 3'd2,
		REG_GREEN_WHITE = 3'd3,
		REG_BLUE_BLACK  = 3'd4,
		REG_BLUE_WHITE  = 3'd5
	} reg_index_t;

	// One restoring step: bring in one dividend bit, subtract if it fits.
	typedef struct packed {
		logic [DIV_D_W-1:0] rem;
		logic               qbit;
	} div_step_t;

	function automatic div_step_t div_step(logic [DIV_D_W-1:0] rem,
		logic nbit, logic [DIV_D_W-1:0] dvs);
		logic [DIV_D_W:0] t;
		div_step_t r;
		t = {rem, nbit};
		if (t >= {1'b0, dvs}) begin
			r.rem  = DIV_D_W'(t - {1'b0, dvs});
			r.qbit = 1'b1;
		end else begin
			r.rem  = t[DIV_D_W-1:0];
			r.qbit = 1'b0;
		end
		return r;
	endfunction

endpackage

>>> design/calibrated_color_classifier.sv
// Top level: calibration registers, three level lanes, HSL merge and color decision.
//
// Usage:
//  - Input channel (valid, ready) carries red_freq, green_freq, blue_freq in hertz.
//  - Output channel (out_valid, out_ready) carries color_class, the three clamped
//    levels, hue_tenths, saturation and lightness for each input beat.
//  - An APB-style port writes the six calibration frequencies at byte addresses
//    0,4,..,20 (red black/white, green black/white, blue black/white); reads
//    return them. Write only while no beat is in flight.
//  - The pipeline runs through the lane dividers, a level register, a merge
//    register, the saturation and hue dividers and an output register.
//  - One beat per clock unless stalled; the 17-stage dividers are fully pipelined.
//  - When the receiver stalls, the whole pipeline holds and ready drops while
//    the output register is full; no beat is lost.
//  - Reset clears all calibration registers to zero and empties the pipeline.
module calibrated_color_classifier (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           valid,
	output logic                           ready,
	input  logic [ccc_pkg::FREQ_W-1:0]     red_freq,
	input  logic [ccc_pkg::FREQ_W-1:0]     green_freq,
	input  logic [ccc_pkg::FREQ_W-1:0]     blue_freq,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ccc_pkg::CLASS_W-1:0]    color_class,
	output logic [ccc_pkg::LVL_W-1:0]      red_level,
	output logic [ccc_pkg::LVL_W-1:0]      green_level,
	output logic [ccc_pkg::LVL_W-1:0]      blue_level,
	output logic [ccc_pkg::HUE_W-1:0]      hue_tenths,
	output logic [ccc_pkg::LVL_W-1:0]      saturation,
	output logic [ccc_pkg::LVL_W-1:0]      lightness,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ccc_pkg::ADDR_W-1:0]     paddr,
	input  logic [ccc_pkg::DATA_W-1:0]     pwdata,
	output logic [ccc_pkg::DATA_W-1:0]     prdata,
	output logic                           pready
);

	localparam int LW = ccc_pkg::LVL_W;
	localparam int SUMW = ccc_pkg::SUM_W;
	localparam int QW = ccc_pkg::DIV_Q_W;
	localparam int NW = ccc_pkg::NUM_W;

	typedef struct packed {
		logic [LW-1:0]   r;
		logic [LW-1:0]   g;
		logic [LW-1:0]   b;
		logic [SUMW-1:0] sum;
		logic            dark;
		logic            bright;
		logic            low_sat;
		logic            flat;
	} side_t;

	// configuration registers
	logic [ccc_pkg::FREQ_W-1:0] cal_q [ccc_pkg::NUM_REGS];
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign ridx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ccc_pkg::NUM_REGS; i++) cal_q[i] <= '0;
		end else if (psel && penable && pwrite) begin
			for (int i = 0; i < ccc_pkg::NUM_REGS; i++) begin
				if (ridx == 3'(i)) cal_q[i] <= pwdata[ccc_pkg::FREQ_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		for (int i = 0; i < ccc_pkg::NUM_REGS; i++) begin
			if (ridx == 3'(i)) prdata = ccc_pkg::DATA_W'(cal_q[i]);
		end
	end

	// pipeline advance: move everything when the output slot is free or drained
	logic adv;
	logic [ccc_pkg::LATENCY-1:0] vld_q;

	assign adv = !out_valid || out_ready;
	assign ready = adv;
	assign out_valid = vld_q[ccc_pkg::LATENCY-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[ccc_pkg::LATENCY-2:0], valid};
	end

	// lanes
	logic [LW-1:0] lvl_r, lvl_g, lvl_b;

	ccc_lane u_lane_r (.clk(clk), .en(adv), .freq(red_freq),
		.black(cal_q[ccc_pkg::REG_RED_BLACK]), .white(cal_q[ccc_pkg::REG_RED_WHITE]),
		.level(lvl_r));
	ccc_lane u_lane_g (.clk(clk), .en(adv), .freq(green_freq),
		.black(cal_q[ccc_pkg::REG_GREEN_BLACK]), .white(cal_q[ccc_pkg::REG_GREEN_WHITE]),
		.level(lvl_g));
	ccc_lane u_lane_b (.clk(clk), .en(adv), .freq(blue_freq),
		.black(cal_q[ccc_pkg::REG_BLUE_BLACK]), .white(cal_q[ccc_pkg::REG_BLUE_WHITE]),
		.level(lvl_b));

	logic [LW-1:0] r_s1, g_s1, b_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1 <= lvl_r;
			g_s1 <= lvl_g;
			b_s1 <= lvl_b;
		end
	end

	// merge: extremes, sum, saturation denominator and hue numerator
	logic [LW-1:0]   mx, mn, delta;
	logic [SUMW-1:0] sum, sden;
	logic signed [NW-1:0] num, dlt_s;
	logic [ccc_pkg::DIV_N_W-1:0] sat_dvd, hue_dvd;
	logic [ccc_pkg::DIV_D_W-1:0] sat_dvs, hue_dvs;
	side_t side;

	always_comb begin
		mx = (r_s1 > g_s1) ? r_s1 : g_s1;
		if (b_s1 > mx) mx = b_s1;
		mn = (r_s1 < g_s1) ? r_s1 : g_s1;
		if (b_s1 < mn) mn = b_s1;
		delta = mx - mn;
		sum = SUMW'(mx) + SUMW'(mn);
		sden = (sum > SUMW'(ccc_pkg::ONE_Q)) ? (SUMW'(2) * SUMW'(ccc_pkg::ONE_Q) - sum) : sum;
		dlt_s = NW'($signed({1'b0, delta}));
		// red sector wins ties, then green
		if (mx == r_s1) begin
			num = NW'(600) * (NW'($signed({1'b0, g_s1})) - NW'($signed({1'b0, b_s1})));
			if (g_s1 < b_s1) num = num + NW'(3600) * dlt_s;
		end else if (mx == g_s1) begin
			num = NW'(600) * (NW'($signed({1'b0, b_s1})) - NW'($signed({1'b0, r_s1})))
				+ NW'(1200) * dlt_s;
		end else begin
			num = NW'(600) * (NW'($signed({1'b0, r_s1})) - NW'($signed({1'b0, g_s1})))
				+ NW'(2400) * dlt_s;
		end
		if (num < 0) num = '0;
		if (delta == '0) begin
			sat_dvd = '0;
			sat_dvs = ccc_pkg::DIV_D_W'(1);
			hue_dvd = '0;
			hue_dvs = ccc_pkg::DIV_D_W'(1);
		end else begin
			sat_dvd = ccc_pkg::DIV_N_W'({delta, {ccc_pkg::FRAC_W{1'b0}}});
			sat_dvs = ccc_pkg::DIV_D_W'(sden);
			hue_dvd = ccc_pkg::DIV_N_W'(unsigned'(num));
			hue_dvs = ccc_pkg::DIV_D_W'(delta);
		end
		side.r = r_s1;
		side.g = g_s1;
		side.b = b_s1;
		side.sum = sum;
		side.dark = (22'(sum) * 22'(10)) < (22'(ccc_pkg::ONE_Q) * 22'(3));
		side.bright = ((21'(r_s1) * 21'(10)) > (21'(ccc_pkg::ONE_Q) * 21'(7)))
			&& ((21'(g_s1) * 21'(10)) > (21'(ccc_pkg::ONE_Q) * 21'(7)))
			&& ((21'(b_s1) * 21'(10)) > (21'(ccc_pkg::ONE_Q) * 21'(7)));
		side.low_sat = (21'(delta) * 21'(5)) < 21'(sden);
		side.flat = (delta == '0);
	end

	logic [ccc_pkg::DIV_N_W-1:0] sat_dvd_s2, hue_dvd_s2;
	logic [ccc_pkg::DIV_D_W-1:0] sat_dvs_s2, hue_dvs_s2;
	side_t side_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			sat_dvd_s2 <= sat_dvd;
			sat_dvs_s2 <= sat_dvs;
			hue_dvd_s2 <= hue_dvd;
			hue_dvs_s2 <= hue_dvs;
			side_s2 <= side;
		end
	end

	logic [QW-1:0] sat_quo, hue_quo;

	ccc_div u_div_sat (.clk(clk), .en(adv), .dividend(sat_dvd_s2),
		.divisor(sat_dvs_s2), .quotient(sat_quo));
	ccc_div u_div_hue (.clk(clk), .en(adv), .dividend(hue_dvd_s2),
		.divisor(hue_dvs_s2), .quotient(hue_quo));

	// hold the side data alongside the dividers
	side_t side_dly [QW];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_dly[0] <= side_s2;
			for (int k = 1; k < QW; k++) side_dly[k] <= side_dly[k-1];
		end
	end

	// decide the class
	side_t sd;
	logic [ccc_pkg::HUE_W-1:0] hue;
	logic [LW-1:0] sat;
	ccc_pkg::color_class_t cls;

	always_comb begin
		sd = side_dly[QW-1];
		if (sd.flat) hue = '0;
		else if (hue_quo > QW'(ccc_pkg::HUE_MAX)) hue = ccc_pkg::HUE_MAX;
		else hue = hue_quo[ccc_pkg::HUE_W-1:0];
		sat = sd.flat ? '0 : LW'(sat_quo);
		if (sd.dark) cls = ccc_pkg::CLS_BLACK;
		else if (sd.bright) cls = ccc_pkg::CLS_WHITE;
		else if (hue >= ccc_pkg::HUE_RED_HI || hue < ccc_pkg::HUE_RED_LO)
			cls = ccc_pkg::CLS_RED;
		else if (hue >= ccc_pkg::HUE_GRN_LO && hue < ccc_pkg::HUE_GRN_HI)
			cls = ccc_pkg::CLS_GREEN;
		else if (hue >= ccc_pkg::HUE_BLU_LO && hue < ccc_pkg::HUE_BLU_HI)
			cls = ccc_pkg::CLS_BLUE;
		else if (sd.flat || sd.low_sat)
			cls = (sd.sum < SUMW'(ccc_pkg::ONE_Q)) ? ccc_pkg::CLS_BLACK : ccc_pkg::CLS_WHITE;
		else cls = ccc_pkg::CLS_UNKNOWN;
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			color_class <= cls;
			red_level   <= sd.r;
			green_level <= sd.g;
			blue_level  <= sd.b;
			hue_tenths  <= hue;
			saturation  <= sat;
			lightness   <= sd.sum[SUMW-1:1];
		end
	end

`ifndef ASSERT_OFF
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hue_tenths <= ccc_pkg::HUE_MAX)
		else $error("hue out of range");
	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> saturation <= ccc_pkg::ONE_Q)
		else $error("saturation above one");
	a_light_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (lightness <= ccc_pkg::ONE_Q && red_level <= ccc_pkg::ONE_Q))
		else $error("level or lightness above one");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> ready)
		else $error("input stalled with empty output");
`endif

endmodule

>>> design/ccc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module ccc_div (
	input  logic                            clk,
	input  logic                            en,
	input  logic [ccc_pkg::DIV_N_W-1:0]     dividend,
	input  logic [ccc_pkg::DIV_D_W-1:0]     divisor,
	output logic [ccc_pkg::DIV_Q_W-1:0]     quotient
);

	localparam int QW = ccc_pkg::DIV_Q_W;
	localparam int DW = ccc_pkg::DIV_D_W;

	logic [DW-1:0] rem_s [QW];
	logic [DW-1:0] dvs_s [QW];
	logic [QW-1:0] low_s [QW];
	logic [QW-1:0] quo_s [QW];

	ccc_pkg::div_step_t step [QW];

	always_comb begin
		step[0] = ccc_pkg::div_step(DW'(dividend[ccc_pkg::DIV_N_W-1:QW]),
			dividend[QW-1], divisor);
		for (int k = 1; k < QW; k++) begin
			step[k] = ccc_pkg::div_step(rem_s[k-1], low_s[k-1][QW-1], dvs_s[k-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= step[0].rem;
			dvs_s[0] <= divisor;
			low_s[0] <= {dividend[QW-2:0], 1'b0};
			quo_s[0] <= {{(QW-1){1'b0}}, step[0].qbit};
			for (int k = 1; k < QW; k++) begin
				rem_s[k] <= step[k].rem;
				dvs_s[k] <= dvs_s[k-1];
				low_s[k] <= {low_s[k-1][QW-2:0], 1'b0};
				quo_s[k] <= {quo_s[k-1][QW-2:0], step[k].qbit};
			end
		end
	end

	assign quotient = quo_s[QW-1];

endmodule

>>> design/ccc_lane.sv
// One color lane: calibrate a frequency against black and white and divide to a level.
module ccc_lane (
	input  logic                          clk,
	input  logic                          en,
	input  logic [ccc_pkg::FREQ_W-1:0]    freq,
	input  logic [ccc_pkg::FREQ_W-1:0]    black,
	input  logic [ccc_pkg::FREQ_W-1:0]    white,
	output logic [ccc_pkg::LVL_W-1:0]     level
);

	localparam int SW = ccc_pkg::FREQ_W + 2;

	logic signed [SW-1:0] n_raw, d_raw, n_abs, d_abs;
	logic                 is_zero, is_one;
	logic [ccc_pkg::DIV_N_W-1:0] dvd;
	logic [ccc_pkg::DIV_D_W-1:0] dvs;
	logic [ccc_pkg::DIV_Q_W-1:0] quo;
	logic [1:0] flag_s [ccc_pkg::DIV_Q_W];

	always_comb begin
		n_raw = SW'($signed({2'b00, freq})) - SW'($signed({2'b00, black}));
		d_raw = SW'($signed({2'b00, white})) - SW'($signed({2'b00, black}));
		// inverted calibration: flip both signs
		n_abs = (d_raw < 0) ? -n_raw : n_raw;
		d_abs = (d_raw < 0) ? -d_raw : d_raw;
		is_zero = (d_abs == 0) || (n_abs <= 0);
		is_one  = !is_zero && (n_abs >= d_abs);
		if (is_zero || is_one) begin
			dvd = '0;
			dvs = ccc_pkg::DIV_D_W'(1);
		end else begin
			dvd = {n_abs[ccc_pkg::DIV_D_W-1:0], {ccc_pkg::FRAC_W{1'b0}}};
			dvs = d_abs[ccc_pkg::DIV_D_W-1:0];
		end
	end

	ccc_div u_div (
		.clk      (clk),
		.en       (en),
		.dividend (dvd),
		.divisor  (dvs),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			flag_s[0] <= {is_zero, is_one};
			for (int k = 1; k < ccc_pkg::DIV_Q_W; k++) begin
				flag_s[k] <= flag_s[k-1];
			end
		end
	end

	always_comb begin
		if (flag_s[ccc_pkg::DIV_Q_W-1][1]) level = '0;
		else if (flag_s[ccc_pkg::DIV_Q_W-1][0]) level = ccc_pkg::ONE_Q;
		else level = ccc_pkg::LVL_W'(quo);
	end

endmodule
